### hw/rtl/psob_pkg.sv
// Shared constants, types and constant tables of the sine oscillator bank.
package psob_pkg;

  localparam int NUM_VOICES       = 13;
  localparam int SAMPLE_RATE_HZ   = 44100;
  localparam int PHASE_BITS       = 32;
  localparam int SINE_TABLE_DEPTH = 1024;

  localparam int VOICE_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int DEPTH_W     = $clog2(SINE_TABLE_DEPTH);
  localparam int SINE_ADDR_W = DEPTH_W + 1;
  localparam int QIDX_W      = DEPTH_W + 2;
  localparam int AMP_W       = 15;
  localparam int SAMPLE_W    = 19;
  localparam int ACC_W       = $clog2(NUM_VOICES * 16384 + 1) + 1;

  localparam int OUT_MAX = 262143;
  localparam int OUT_MIN = -262144;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic [PHASE_BITS-1:0] phase_t;
  typedef logic [AMP_W-1:0]      amp_t;
  typedef phase_t inc_tab_t [NUM_VOICES];
  typedef amp_t   sine_tab_t [SINE_TABLE_DEPTH+1];

  // C4 to B4 in Q16 Hz, equal temperament around A4 at 440 Hz.
  localparam logic [31:0] BASE_FREQ_Q16 [12] = '{
    32'd17145893, 32'd18165441, 32'd19245614, 32'd20390018,
    32'd21602472, 32'd22887021, 32'd24247954, 32'd25689813,
    32'd27217409, 32'd28835840, 32'd30550508, 32'd32367136
  };

  function automatic inc_tab_t build_inc_tab();
    inc_tab_t             tab;
    logic [63:0]          f;
    logic [63:0]          num;
    for (int k = 0; k < NUM_VOICES; k++) begin
      f = 64'(BASE_FREQ_Q16[k % 12]) << (k / 12);
      num = f << (PHASE_BITS - 16);
      tab[k] = PHASE_BITS'((num + 64'(SAMPLE_RATE_HZ / 2)) / 64'(SAMPLE_RATE_HZ));
    end
    return tab;
  endfunction

  // Quarter-wave entry from a Taylor series in Q30, rounded to half amplitude.
  function automatic amp_t quarter_entry(int m);
    logic [63:0]        x;
    logic [63:0]        t;
    logic signed [63:0] s;
    logic [63:0]        r;
    x = (HALF_PI_Q30 * 64'(m)) / SINE_TABLE_DEPTH;
    t = x;
    s = $signed(x);
    for (int j = 0; j < 7; j++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      case (j)
        0:       t = t / 6;
        1:       t = t / 20;
        2:       t = t / 42;
        3:       t = t / 72;
        4:       t = t / 110;
        5:       t = t / 156;
        default: t = t / 210;
      endcase
      if (j % 2 == 0) begin
        s = s - $signed(t);
      end else begin
        s = s + $signed(t);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    if (s > 64'sd1073741824) begin
      s = 64'sd1073741824;
    end
    r = ((64'(s) * 64'd16384) + 64'd536870912) >> 30;
    return AMP_W'(r);
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int m = 0; m <= SINE_TABLE_DEPTH; m++) begin
      tab[m] = quarter_entry(m);
    end
    return tab;
  endfunction

  localparam inc_tab_t VOICE_INC = build_inc_tab();

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_TOGGLE = 1'b1;

endpackage

### hw/rtl/psob_sine_rom.sv
// Quarter-wave half-amplitude sine table with a registered read port.
module psob_sine_rom import psob_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [SINE_ADDR_W-1:0] addr_i,
  output amp_t                   data_o
);

  localparam sine_tab_t SineTab = build_sine_tab();

  amp_t data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= SineTab[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

### hw/rtl/polyphonic_sine_oscillator_bank.sv
// Top level of the sine oscillator bank: voice sequencer, phase store and mixer.
// A tick word is followed by its sample after the scan, flush and done states; done waits for the output.
// The voices go one per cycle through one phase adder, one table read and one
// accumulator, so a tick holds the input not ready until the sample is loaded out.
// A toggle word gives no result; the input is ready again at once.
// Reset (rst_ni low, asynchronous) turns all voices off and clears every phase.
module polyphonic_sine_oscillator_bank import psob_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [3:0] voice, [7:4] zero
  input  logic        s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [18:0] sample, [23:19] zero
);

  state_e state_q, state_d;
  logic [VOICE_W-1:0]     k_q;
  logic [NUM_VOICES-1:0]  key_on_q;
  phase_t                 phase_q [NUM_VOICES];
  logic                   vld1_q;
  logic                   neg_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                   m_valid_q;
  logic [SAMPLE_W-1:0]    m_data_q;

  logic                   in_fire;
  logic                   voice_hit;
  logic [3:0]             voice;
  logic                   scanning;
  logic                   lane_on;
  logic [QIDX_W-1:0]      qidx;
  logic [DEPTH_W-1:0]     rem;
  logic [SINE_ADDR_W-1:0] rom_addr;
  amp_t                   rom_data;
  logic signed [ACC_W-1:0] term;
  logic                   last_voice;
  logic                   out_load;
  logic signed [SAMPLE_W-1:0] sat;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign voice         = s_axis_tdata[3:0];
  assign voice_hit     = (32'(voice) < NUM_VOICES);

  assign scanning   = (state_q == ST_SCAN);
  assign lane_on    = scanning && key_on_q[k_q];
  assign last_voice = (32'(k_q) == NUM_VOICES - 1);

  // Phase top bits give quadrant and offset; odd quadrants mirror the table.
  assign qidx     = phase_q[k_q][PHASE_BITS-1 -: QIDX_W];
  assign rem      = qidx[DEPTH_W-1:0];
  assign rom_addr = qidx[DEPTH_W] ? (SINE_ADDR_W'(SINE_TABLE_DEPTH) - {1'b0, rem})
                                  : {1'b0, rem};

  psob_sine_rom u_rom (
    .clk_i  (clk_i),
    .en_i   (lane_on),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  assign term = neg_q ? -$signed(ACC_W'(rom_data)) : $signed(ACC_W'(rom_data));

  assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  always_comb begin
    if (acc_q > ACC_W'(OUT_MAX)) begin
      sat = SAMPLE_W'(OUT_MAX);
    end else if (acc_q < ACC_W'(OUT_MIN)) begin
      sat = SAMPLE_W'(OUT_MIN);
    end else begin
      sat = SAMPLE_W'(acc_q);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && s_axis_tuser == ACT_TICK) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_voice) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      k_q       <= '0;
      key_on_q  <= '0;
      vld1_q    <= 1'b0;
      m_valid_q <= 1'b0;
      for (int v = 0; v < NUM_VOICES; v++) begin
        phase_q[v] <= '0;
      end
    end else begin
      state_q <= state_d;
      vld1_q  <= lane_on;
      if (in_fire && s_axis_tuser == ACT_TOGGLE && voice_hit) begin
        key_on_q[VOICE_W'(voice)] <= !key_on_q[VOICE_W'(voice)];
      end
      if (in_fire) begin
        k_q <= '0;
      end else if (scanning && !last_voice) begin
        k_q <= k_q + 1'b1;
      end
      if (lane_on) begin
        phase_q[k_q] <= phase_q[k_q] + VOICE_INC[k_q];
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lane_on) begin
      neg_q <= qidx[DEPTH_W+1];
    end
    if (in_fire) begin
      acc_q <= '0;
    end else if (vld1_q) begin
      acc_q <= acc_q + term;
    end
    if (out_load) begin
      m_data_q <= sat;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b0, m_data_q};

endmodule

### hw/rtl/psob_checker.sv
// Port-level checks of the sine oscillator bank, bound to the top level.
module psob_checker import psob_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // A tick keeps the block busy while the voices are scanned.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_TICK) |=> !s_axis_tready)
    else $error("input ready right after a tick word");

  // After a toggle is taken, the input is ready again in the next cycle.
  a_toggle_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_TOGGLE) |=> s_axis_tready)
    else $error("input not ready after a toggle word");

  // Padding above the sample field stays zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[23:19] == 5'b0))
    else $error("output padding bits not zero");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output word changed");

endmodule

bind polyphonic_sine_oscillator_bank psob_checker u_psob_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
